[design/jse_pkg.sv]
// shared types, character codes and helper functions for the json string escaper
`timescale 1ns / 1ps

package jse_pkg;

  localparam int MaxOut = 14;

  localparam logic [6:0] ChQuote  = 7'h22;
  localparam logic [6:0] ChBslash = 7'h5C;
  localparam logic [6:0] ChLowB   = 7'h62;
  localparam logic [6:0] ChLowF   = 7'h66;
  localparam logic [6:0] ChLowN   = 7'h6E;
  localparam logic [6:0] ChLowR   = 7'h72;
  localparam logic [6:0] ChLowT   = 7'h74;
  localparam logic [6:0] ChLowU   = 7'h75;

  localparam logic [20:0] CpQuote  = 21'h00022;
  localparam logic [20:0] CpBslash = 21'h0005C;
  localparam logic [20:0] CpBs     = 21'h00008;
  localparam logic [20:0] CpFf     = 21'h0000C;
  localparam logic [20:0] CpLf     = 21'h0000A;
  localparam logic [20:0] CpCr     = 21'h0000D;
  localparam logic [20:0] CpTab    = 21'h00009;

  typedef struct packed {
    logic        in_str;
    logic [1:0]  pending;
    logic [20:0] acc;
  } state_t;

  typedef struct packed {
    logic [MaxOut-1:0][6:0] chars;
    logic [3:0]             count;
    logic                   close;
  } job_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'd0, nib};
    end else begin
      ch = 7'h57 + {3'd0, nib};
    end
    return ch;
  endfunction

  // \uXXXX, backslash in the lowest slot
  function automatic logic [5:0][6:0] unit_chars(input logic [15:0] v);
    logic [5:0][6:0] u;
    u[0] = ChBslash;
    u[1] = ChLowU;
    u[2] = hex_char(v[15:12]);
    u[3] = hex_char(v[11:8]);
    u[4] = hex_char(v[7:4]);
    u[5] = hex_char(v[3:0]);
    return u;
  endfunction

endpackage

[design/jse_encode.sv]
// utf-8 decode step and escaped character list for one input item
`timescale 1ns / 1ps

module jse_encode (
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            empty_string,
  input  jse_pkg::state_t st,
  output jse_pkg::state_t st_next,
  output jse_pkg::job_t   job
);

  logic        ready;
  logic        open_q;
  logic [1:0]  pend;
  logic [20:0] acc;
  logic [20:0] cp;
  logic [20:0] v;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [11:0][6:0] body;
  logic [3:0]  body_n;

  // decode
  always_comb begin
    ready  = 1'b0;
    pend   = st.pending;
    acc    = st.acc;
    cp     = '0;
    if (st.pending == 2'd0) begin
      if (data_byte[7] == 1'b0) begin
        acc   = {13'd0, data_byte};
        ready = 1'b1;
      end else if (data_byte[7:5] == 3'b110) begin
        acc  = {16'd0, data_byte[4:0]};
        pend = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        acc  = {17'd0, data_byte[3:0]};
        pend = 2'd2;
      end else begin
        acc  = {18'd0, data_byte[2:0]};
        pend = 2'd3;
      end
    end else begin
      acc  = {st.acc[14:0], data_byte[5:0]};
      pend = st.pending - 2'd1;
      if (pend == 2'd0) begin
        ready = 1'b1;
      end
    end
    // truncated sequence flushed at end of string
    if (last_byte && pend != 2'd0) begin
      pend  = 2'd0;
      ready = 1'b1;
    end
    cp = acc;
    if (ready) begin
      acc = '0;
    end
    if (empty_string) begin
      st_next = '0;
    end else begin
      st_next.in_str  = ~last_byte;
      st_next.pending = pend;
      st_next.acc     = acc;
    end
  end

  assign v       = cp - 21'h10000;
  assign hi_unit = 16'hD800 + {5'd0, v[20:10]};
  assign lo_unit = 16'hDC00 + {6'd0, v[9:0]};

  // escaped text of the code point
  always_comb begin
    body   = '0;
    body_n = 4'd0;
    if (ready) begin
      body[0] = jse_pkg::ChBslash;
      body_n  = 4'd2;
      unique case (cp)
        jse_pkg::CpQuote:  body[1] = jse_pkg::ChQuote;
        jse_pkg::CpBslash: body[1] = jse_pkg::ChBslash;
        jse_pkg::CpBs:     body[1] = jse_pkg::ChLowB;
        jse_pkg::CpFf:     body[1] = jse_pkg::ChLowF;
        jse_pkg::CpLf:     body[1] = jse_pkg::ChLowN;
        jse_pkg::CpCr:     body[1] = jse_pkg::ChLowR;
        jse_pkg::CpTab:    body[1] = jse_pkg::ChLowT;
        default: begin
          if (cp < 21'h20 || (cp >= 21'h80 && cp <= 21'hFFFF)) begin
            body[5:0] = jse_pkg::unit_chars(cp[15:0]);
            body_n    = 4'd6;
          end else if (cp < 21'h80) begin
            body[0] = cp[6:0];
            body_n  = 4'd1;
          end else begin
            body[5:0]  = jse_pkg::unit_chars(hi_unit);
            body[11:6] = jse_pkg::unit_chars(lo_unit);
            body_n     = 4'd12;
          end
        end
      endcase
    end
  end

  assign open_q = ~st.in_str;

  // opening quote, body, closing quote
  always_comb begin
    logic [3:0] k;
    k = '0;
    job = '0;
    if (empty_string) begin
      job.chars[0] = jse_pkg::ChQuote;
      job.chars[1] = jse_pkg::ChQuote;
      job.count    = 4'd2;
      job.close    = 1'b1;
    end else begin
      for (int i = 0; i < jse_pkg::MaxOut; i++) begin
        k = 4'(i) - {3'd0, open_q};
        if (open_q && i == 0) begin
          job.chars[i] = jse_pkg::ChQuote;
        end else if (k < body_n) begin
          job.chars[i] = body[k];
        end else begin
          job.chars[i] = jse_pkg::ChQuote;
        end
      end
      job.count = {3'd0, open_q} + body_n + {3'd0, last_byte};
      job.close = last_byte;
    end
  end

endmodule

[design/json_string_escape_ascii_top.sv]
// top level of the json string escaper: state, result register and output sequencing
//
//  channel  dir  tdata                     tlast     tuser
//  s_axis   in   [7:0] data_byte           last_byte empty_string
//  m_axis   out  [6:0] out_byte, [7] zero  run_last  string_done
//
// an item is decoded in the cycle it is accepted and its characters are loaded
// into the result register; one character leaves per cycle after that while m_tready is high
// an item holds off further input until its last character is taken, which is when
// the next item can be accepted; a lead byte with no characters sends nothing
// rst (synchronous) clears the string state and drops any pending characters
// a stall on m_axis holds the current character and blocks further items
`timescale 1ns / 1ps

module json_string_escape_ascii_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       s_tuser,   // empty_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_byte, [7] zero
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // string_done
);

  jse_pkg::state_t st;
  jse_pkg::state_t st_next;
  jse_pkg::job_t   job_in;
  jse_pkg::job_t   job;
  logic            job_valid;
  logic [3:0]      idx;
  logic            at_end;
  logic            take;
  logic            s_acc;

  jse_encode u_encode (
    .data_byte    (s_tdata),
    .last_byte    (s_tlast),
    .empty_string (s_tuser),
    .st           (st),
    .st_next      (st_next),
    .job          (job_in)
  );

  assign at_end   = (idx == job.count - 4'd1);
  assign take     = job_valid & m_tready;
  assign s_tready = ~job_valid | (m_tready & at_end);
  assign s_acc    = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      job_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (s_acc) begin
        st <= st_next;
      end
      if (s_acc) begin
        job_valid <= (job_in.count != 4'd0);
        idx       <= '0;
      end else if (take) begin
        if (at_end) begin
          job_valid <= 1'b0;
        end
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      job <= job_in;
    end
  end

  assign m_tvalid = job_valid;
  assign m_tdata  = {1'b0, job.chars[idx]};
  assign m_tlast  = at_end;
  assign m_tuser  = at_end & job.close;

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> job.count != 4'd0)
    else $error("result register holds an empty item");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> idx < job.count)
    else $error("character index past item length");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("closing quote not last character of its item");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
